// File: rtl/gzsg_pkg.sv
// ----------------------------------------------------------------------------
// gzsg_pkg
// shared constants and types of the gyro zero stillness gate
// ----------------------------------------------------------------------------
package gzsg_pkg;

    localparam int MAX_BLOCK_DEF  = 1024;
    localparam int MAX_WINDOW_DEF = 65536;

    localparam logic [2:0] REG_BLOCK_LEN  = 3'd0;
    localparam logic [2:0] REG_WINDOW_LEN = 3'd1;
    localparam logic [2:0] REG_RATE_SD    = 3'd2;
    localparam logic [2:0] REG_ACCEL_SD   = 3'd3;
    localparam logic [2:0] REG_ACCEL_ERR  = 3'd4;

    localparam logic [1:0] ST_COLLECT  = 2'd0;
    localparam logic [1:0] ST_FAILED   = 2'd1;
    localparam logic [1:0] ST_BANKED   = 2'd2;
    localparam logic [1:0] ST_ACCEPTED = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_SPREAD,
        S_RHS,
        S_JUDGE,
        S_DIV,
        S_OUT
    } t_state;

    // multiplier request from sequencer to shared unit
    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

endpackage

// File: rtl/gzsg_mul.sv
// ----------------------------------------------------------------------------
// gzsg_mul
// shared 64 by 64 multiplier keeping the low 64 bits of the product, built from 32 by 32 partial products
// ----------------------------------------------------------------------------
module gzsg_mul
    import gzsg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_mul_req    i_req,
    output logic        o_done,
    output logic [63:0] o_prod
);
    logic [63:0] r_a, n_a;
    logic [63:0] r_b, n_b;
    logic [63:0] r_acc, n_acc;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [31:0] w_pa, w_pb;
    logic [63:0] w_pp;

    assign w_pa = r_cnt[1] ? r_a[63:32] : r_a[31:0];
    assign w_pb = r_cnt[0] ? r_b[63:32] : r_b[31:0];
    assign w_pp = 64'(w_pa) * 64'(w_pb);

    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_acc = r_acc;
        n_cnt = r_cnt;
        n_busy = r_busy;
        o_done = 1'b0;
        if (i_start) begin
            n_a = i_req.a;
            n_b = i_req.b;
            n_acc = '0;
            n_cnt = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            case (r_cnt[1:0])
                2'd0: n_acc = r_acc + w_pp;
                2'd1, 2'd2: n_acc = r_acc + {w_pp[31:0], 32'd0};
                default: n_acc = r_acc;
            endcase
            n_cnt = r_cnt + 3'd1;
            if (r_cnt == 3'd3) begin
                n_busy = 1'b0;
                o_done = 1'b1;
            end
        end
    end

    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt <= n_cnt;
        end
        r_a <= n_a;
        r_b <= n_b;
        r_acc <= n_acc;
    end
endmodule

// File: rtl/gzsg_div.sv
// ----------------------------------------------------------------------------
// gzsg_div
// restoring divider, one quotient bit a cycle
// ----------------------------------------------------------------------------
module gzsg_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_num,
    input  logic [17:0] i_den,
    output logic        o_done,
    output logic [47:0] o_quot
);
    logic [47:0] r_q;
    logic [18:0] r_rem;
    logic [17:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [19:0] w_trial;

    assign w_trial = {r_rem, r_q[47]} - {2'b0, r_den};
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd47) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_q <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_trial[19]) begin
                r_rem <= w_trial[18:0];
                r_q <= {r_q[46:0], 1'b1};
            end else begin
                r_rem <= {r_rem[17:0], r_q[47]};
                r_q <= {r_q[46:0], 1'b0};
            end
        end
    end
endmodule

// File: rtl/gyro_zero_stillness_gate_unit.sv
// ----------------------------------------------------------------------------
// gyro_zero_stillness_gate_unit
// startup gyro zero-rate estimator gated by a stillness check
// ----------------------------------------------------------------------------
// usage: one input beat carries a three-axis raw rate sample and the
// accelerometer magnitude; each input beat gives exactly one output beat with
// ready flag, gate status, the three offsets and the two tallies.
// flow: an ordinary sample passes from the accumulate state straight to its
// output beat; a block end runs the squared-form variance checks through the
// shared multiplier (thirteen products in turn), and an accepting block adds
// three divisions. once accepted, a beat also goes straight from the
// accumulate state to its output beat. output stalls hold all of these.
// one item is handled at a time; input stall is high from acceptance until
// the output beat has been taken.
// reset (synchronous, active low) clears statistics, tallies and offsets and
// loads the register defaults.
// when the receiver stalls, the output beat holds and no new input is taken.
// configuration writes must only be made while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module gyro_zero_stillness_gate_unit
    import gzsg_pkg::*;
#(
    parameter int MAX_BLOCK  = MAX_BLOCK_DEF,
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_rate_x,
    input  logic signed [15:0] i_rate_y,
    input  logic signed [15:0] i_rate_z,
    input  logic [15:0]        i_gravity_norm,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_zero_ready,
    output logic [1:0]         o_gate_status,
    output logic signed [23:0] o_offset_x,
    output logic signed [23:0] o_offset_y,
    output logic signed [23:0] o_offset_z,
    output logic [15:0]        o_failed_blocks,
    output logic [15:0]        o_restart_count
);
    localparam int BW = $clog2(MAX_BLOCK + 1);
    localparam int WW = $clog2(MAX_WINDOW + MAX_BLOCK + 1);

    logic [10:0] r_block_len;
    logic [15:0] r_window_len, r_rate_sd, r_accel_sd, r_accel_err;

    t_state r_state, n_state;
    logic [BW-1:0] r_bcnt;
    logic signed [26:0] r_bs [3];
    logic [40:0] r_bq [3];
    logic signed [27:0] r_ds;
    logic [41:0] r_dq;
    logic [WW-1:0] r_wcnt;
    logic signed [33:0] r_ws [3];
    logic r_acc;
    logic signed [23:0] r_bias [3];
    logic [15:0] r_fail, r_rst;
    logic [1:0] r_status;
    logic signed [15:0] r_in [4];
    logic [3:0] r_step;
    logic [63:0] r_p0, r_rnum, r_anum, r_rrhs, r_arhs, r_nn;
    logic [1:0] r_ax;
    logic r_busy;
    logic r_ovf;

    logic [BW-1:0] w_eff;
    logic [WW-1:0] w_need;
    logic [63:0] w_n;
    logic        w_mstart, w_mdone;
    t_mul_req    w_req;
    logic [63:0] w_prod;
    logic        w_dstart, w_ddone;
    logic [47:0] w_dnum, w_dq;
    logic [17:0] w_dden;
    logic [63:0] w_mag [3];
    logic [63:0] w_dmag;
    logic        w_bend;
    logic [63:0] w_errn;
    logic        w_still;
    logic [WW-1:0] w_nw;

    always_comb begin
        if (r_block_len < 11'd2) w_eff = BW'(2);
        else if (32'(r_block_len) > MAX_BLOCK) w_eff = BW'(MAX_BLOCK);
        else w_eff = BW'(r_block_len);
        if (32'(r_window_len) > MAX_WINDOW) w_need = WW'(MAX_WINDOW);
        else w_need = WW'(r_window_len);
    end

    assign w_n = 64'(r_bcnt);
    for (genvar g = 0; g < 3; g++) begin : g_mag
        assign w_mag[g] = r_bs[g][26] ? 64'(-$signed(64'(r_bs[g]))) : 64'(r_bs[g]);
    end
    assign w_dmag = r_ds[27] ? 64'(-$signed(64'(r_ds))) : 64'(r_ds);

    // block end and stillness decision
    assign w_bend = (r_bcnt + BW'(1)) >= w_eff;
    assign w_errn = 64'(28'(r_accel_err) * 28'(r_bcnt));
    assign w_still = r_rnum[63:48] == 16'd0 && {r_rnum[47:0], 16'd0} <= r_rrhs
                     && r_anum <= r_arhs
                     && w_dmag <= w_errn;
    assign w_nw = r_wcnt + WW'(r_bcnt);

    // multiplier operand select by step
    always_comb begin
        w_req = '0;
        case (r_step)
            4'd0: w_req = '{a: w_n, b: 64'(r_bq[r_ax])};
            4'd1: w_req = '{a: w_mag[r_ax], b: w_mag[r_ax]};
            4'd2: w_req = '{a: w_n, b: 64'(r_dq)};
            4'd3: w_req = '{a: w_dmag, b: w_dmag};
            4'd4: w_req = '{a: w_n, b: w_n - 64'd1};
            4'd5: w_req = '{a: 64'(r_rate_sd), b: 64'(r_rate_sd)};
            4'd6: w_req = '{a: w_prod, b: r_nn};
            4'd7: w_req = '{a: 64'(r_accel_sd), b: 64'(r_accel_sd)};
            4'd8: w_req = '{a: w_prod, b: r_nn};
            default: w_req = '0;
        endcase
    end

    gzsg_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mstart), .i_req(w_req),
        .o_done(w_mdone), .o_prod(w_prod)
    );

    logic signed [33:0] w_wsel;
    logic [33:0] w_wmag;
    assign w_wsel = r_ws[r_ax];
    assign w_wmag = w_wsel[33] ? 34'(-w_wsel) : w_wsel;
    assign w_dnum = 48'({w_wmag, 9'd0}) + 48'(r_wcnt);
    assign w_dden = 18'({r_wcnt, 1'b0});

    gzsg_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart), .i_num(w_dnum),
        .i_den(w_dden), .o_done(w_ddone), .o_quot(w_dq)
    );

    assign o_stall = r_state != S_IDLE;
    assign o_valid = r_state == S_OUT;
    assign o_zero_ready = r_acc;
    assign o_gate_status = r_status;
    assign o_offset_x = r_bias[0];
    assign o_offset_y = r_bias[1];
    assign o_offset_z = r_bias[2];
    assign o_failed_blocks = r_fail;
    assign o_restart_count = r_rst;

    assign w_mstart = r_busy == 1'b0 && (r_state == S_SPREAD || r_state == S_RHS);
    assign w_dstart = r_busy == 1'b0 && r_state == S_DIV;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_valid) n_state = S_ACC;
            S_ACC:    if (!r_acc && w_bend) n_state = S_SPREAD;
                      else n_state = S_OUT;
            S_SPREAD: if (w_mdone && r_step == 4'd3) n_state = S_RHS;
            S_RHS:    if (w_mdone && r_step == 4'd8) n_state = S_JUDGE;
            S_JUDGE:  if (w_still && w_nw >= w_need) n_state = S_DIV;
                      else n_state = S_OUT;
            S_DIV:    if (w_ddone && r_ax == 2'd2) n_state = S_OUT;
            S_OUT:    if (!i_stall) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_len <= 11'd100;
            r_window_len <= 16'd1000;
            r_rate_sd <= 16'd256;
            r_accel_sd <= 16'd82;
            r_accel_err <= 16'd410;
            r_state <= S_IDLE;
            r_bcnt <= '0;
            r_ds <= '0;
            r_dq <= '0;
            r_wcnt <= '0;
            r_acc <= 1'b0;
            r_fail <= '0;
            r_rst <= '0;
            r_status <= ST_COLLECT;
            r_busy <= 1'b0;
            r_step <= '0;
            r_ax <= '0;
            for (int i = 0; i < 3; i++) begin
                r_bs[i] <= '0;
                r_bq[i] <= '0;
                r_ws[i] <= '0;
                r_bias[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BLOCK_LEN:  r_block_len <= i_cfg_data[10:0];
                    REG_WINDOW_LEN: r_window_len <= i_cfg_data;
                    REG_RATE_SD:    r_rate_sd <= i_cfg_data;
                    REG_ACCEL_SD:   r_accel_sd <= i_cfg_data;
                    REG_ACCEL_ERR:  r_accel_err <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_in[0] <= i_rate_x;
                    r_in[1] <= i_rate_y;
                    r_in[2] <= i_rate_z;
                    r_in[3] <= $signed(i_gravity_norm - 16'd8192);
                    r_ovf <= i_gravity_norm[15] & (i_gravity_norm[14:13] != 2'b00);
                end
                S_ACC: begin
                    if (r_acc) begin
                        r_status <= ST_ACCEPTED;
                    end else begin
                        logic signed [16:0] d;
                        d = $signed(17'(r_in[3])) + (r_ovf ? 17'sh10000 : 17'sh0);
                        for (int i = 0; i < 3; i++) begin
                            r_bs[i] <= r_bs[i] + 27'(r_in[i]);
                            r_bq[i] <= r_bq[i] + 41'($unsigned(32'(r_in[i] * r_in[i])));
                        end
                        r_ds <= r_ds + 28'(d);
                        r_dq <= r_dq + 42'($unsigned(34'(d * d)));
                        r_bcnt <= r_bcnt + BW'(1);
                        r_status <= ST_COLLECT;
                        if (w_bend) begin
                            r_step <= '0;
                            r_ax <= '0;
                            r_rnum <= '0;
                        end
                    end
                end
                S_SPREAD: begin
                    if (w_mstart) r_busy <= 1'b1;
                    if (w_mdone) begin
                        r_busy <= 1'b0;
                        case (r_step)
                            4'd0, 4'd2: begin
                                r_p0 <= w_prod;
                                r_step <= r_step + 4'd1;
                            end
                            4'd1: begin
                                if (r_p0 > w_prod) r_rnum <= r_rnum + (r_p0 - w_prod);
                                if (r_ax == 2'd2) r_step <= 4'd2;
                                else begin
                                    r_ax <= r_ax + 2'd1;
                                    r_step <= 4'd0;
                                end
                            end
                            default: begin
                                r_anum <= (r_p0 > w_prod) ? r_p0 - w_prod : 64'd0;
                                r_step <= 4'd4;
                            end
                        endcase
                    end
                end
                S_RHS: begin
                    if (w_mstart) r_busy <= 1'b1;
                    if (w_mdone) begin
                        r_busy <= 1'b0;
                        r_step <= r_step + 4'd1;
                        case (r_step)
                            4'd4: r_nn <= w_prod;
                            4'd6: r_rrhs <= w_prod;
                            4'd8: r_arhs <= w_prod;
                            default: ;
                        endcase
                    end
                end
                S_JUDGE: begin
                    r_bcnt <= '0;
                    r_ds <= '0;
                    r_dq <= '0;
                    for (int i = 0; i < 3; i++) begin
                        r_bs[i] <= '0;
                        r_bq[i] <= '0;
                    end
                    if (!w_still) begin
                        r_status <= ST_FAILED;
                        if (r_fail != 16'hFFFF) r_fail <= r_fail + 16'd1;
                        if (r_wcnt != '0) begin
                            if (r_rst != 16'hFFFF) r_rst <= r_rst + 16'd1;
                            r_wcnt <= '0;
                            for (int i = 0; i < 3; i++) r_ws[i] <= '0;
                        end
                    end else begin
                        r_status <= ST_BANKED;
                        for (int i = 0; i < 3; i++) r_ws[i] <= r_ws[i] + 34'(r_bs[i]);
                        r_wcnt <= w_nw;
                        if (w_nw >= w_need) r_ax <= '0;
                    end
                end
                S_DIV: begin
                    if (w_dstart) r_busy <= 1'b1;
                    if (w_ddone) begin
                        r_busy <= 1'b0;
                        r_bias[r_ax] <= w_wsel[33] ? -24'(w_dq) : 24'(w_dq);
                        if (r_ax == 2'd2) begin
                            r_acc <= 1'b1;
                            r_status <= ST_ACCEPTED;
                        end else r_ax <= r_ax + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_gate_status))
        else $error("output beat changed under stall");
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while result pending");
    a_ready_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_zero_ready |=> o_zero_ready)
        else $error("zero ready dropped");
endmodule
